### src/wstc_pkg.sv
// Shared types and constants of the wheel speed trip computer.
package wstc_pkg;

    localparam int TIME_WIDTH_DEF  = 48;
    localparam int COUNT_WIDTH_DEF = 32;

    localparam int CIRC_W   = 12;
    localparam int Q8_W     = 16;
    localparam int START_W  = 48;
    localparam int CFG_W    = 48;
    localparam int CFG_IDX_W = 3;
    localparam int LHS_W    = 38;
    localparam int A9_W     = 20;
    localparam int C3600_W  = 24;
    localparam int SPDNUM_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_CIRC      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIDE_START = 3'd4;

    localparam logic [CIRC_W-1:0] CIRC_RST      = 12'd2100;
    localparam logic [Q8_W-1:0]   MAX_ACCEL_RST = 16'd2560;
    localparam logic [Q8_W-1:0]   MAX_SPEED_RST = 16'd25600;
    localparam logic [Q8_W-1:0]   MIN_SPEED_RST = 16'd256;

    localparam int K_SPEED = 921600;
    localparam int K_HOUR  = 3600;
    localparam int K_ACCEL = 2500000;
    localparam int K_A9    = 9;

    localparam logic [7:0]  KMH_CAP    = 8'd100;
    localparam logic [7:0]  KMH_FORCED = 8'd99;
    localparam logic [Q8_W-1:0] AVG_MAX = 16'hFFFF;

    localparam logic KIND_DETECT = 1'b0;

    typedef enum logic [1:0] {
        DS_SPEED = 2'd0,
        DS_QUERY = 2'd1,
        DS_ACCEL = 2'd2,
        DS_AVG   = 2'd3
    } t_dsel;

    typedef struct packed {
        logic  load;
        logic  prep;
        logic  start;
        t_dsel sel;
        logic  qfix;
        logic  qdiv;
        logic  save_spd;
        logic  upd;
        logic  avg_zero;
        logic  avg_div;
        logic  out_load;
    } t_cmd;

    typedef struct packed {
        logic kind;
        logic count_zero;
        logic ref_late;
        logic q_after;
        logic el_pos;
        logic div_done;
        logic win_bad;
        logic acc_up;
        logic a9_zero;
        logic acc_bad;
        logic out_free;
    } t_status;

endpackage

### src/wstc_divider.sv
// Restoring divider, one quotient bit per cycle.
module wstc_divider #(
    parameter int DVD_W = 56,
    parameter int DVS_W = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quot,
    output logic [DVS_W-1:0] o_rem
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             ge;

    always_comb begin
        rem_sh = {r_rem, r_quot[DVD_W-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        diff   = rem_sh - {1'b0, r_dvs};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quot <= i_dividend;
            r_rem  <= '0;
            r_dvs  <= i_divisor;
        end else if (r_busy) begin
            r_quot <= {r_quot[DVD_W-2:0], ge};
            r_rem  <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
    assign o_rem  = r_rem;
endmodule

### src/wstc_datapath.sv
// Registers, arithmetic and output stage of the trip computer.
module wstc_datapath #(
    parameter int TIME_WIDTH  = wstc_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = wstc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [wstc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wstc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_kind,
    input  logic [47:0]                    i_now,
    input  wstc_pkg::t_cmd                 i_cmd,
    output wstc_pkg::t_status              o_st,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [175:0]                   o_m_tdata,
    output logic                           o_m_tuser
);
    localparam int DVD_W  = (COUNT_WIDTH + wstc_pkg::C3600_W > wstc_pkg::LHS_W) ?
                            COUNT_WIDTH + wstc_pkg::C3600_W : wstc_pkg::LHS_W;
    localparam int WIDE_W = (TIME_WIDTH > DVD_W) ? TIME_WIDTH : DVD_W;

    // configuration
    logic [wstc_pkg::CIRC_W-1:0]  r_circ;
    logic [wstc_pkg::Q8_W-1:0]    r_max_accel;
    logic [wstc_pkg::Q8_W-1:0]    r_max_speed;
    logic [wstc_pkg::Q8_W-1:0]    r_min_speed;
    logic [wstc_pkg::START_W-1:0] r_ride_start;

    // held state
    logic [wstc_pkg::Q8_W-1:0] r_held;
    logic [wstc_pkg::Q8_W-1:0] r_prior;
    logic [COUNT_WIDTH-1:0]    r_count;
    logic [TIME_WIDTH-1:0]     r_last;
    logic [TIME_WIDTH-1:0]     r_before;
    logic [wstc_pkg::Q8_W-1:0] r_held_avg;

    // per-item work
    logic                          r_kind;
    logic [TIME_WIDTH-1:0]         r_now;
    logic [TIME_WIDTH-1:0]         r_dt;
    logic [TIME_WIDTH-1:0]         r_el;
    logic                          r_el_pos;
    logic [wstc_pkg::C3600_W-1:0]  r_c3600;
    logic [wstc_pkg::Q8_W-1:0]     r_spd;
    logic [wstc_pkg::Q8_W-1:0]     r_res_speed;
    logic [wstc_pkg::Q8_W-1:0]     r_res_avg;
    logic                          r_ok;

    logic         r_valid;
    logic [175:0] r_tdata;
    logic         r_tuser;

    logic [TIME_WIDTH-1:0]        start_t;
    logic [TIME_WIDTH-1:0]        ref_t;
    logic [TIME_WIDTH-1:0]        dt_c;
    logic [wstc_pkg::C3600_W-1:0] c3600_c;
    logic [wstc_pkg::LHS_W-1:0]   lhs;
    logic [wstc_pkg::A9_W-1:0]    a9;
    logic [DVD_W-1:0]             dvd;
    logic [TIME_WIDTH-1:0]        dvs;
    logic [DVD_W-1:0]             quot;
    logic [TIME_WIDTH-1:0]        rem;
    logic                         div_done;
    logic                         out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_circ       <= wstc_pkg::CIRC_RST;
            r_max_accel  <= wstc_pkg::MAX_ACCEL_RST;
            r_max_speed  <= wstc_pkg::MAX_SPEED_RST;
            r_min_speed  <= wstc_pkg::MIN_SPEED_RST;
            r_ride_start <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                wstc_pkg::CFG_CIRC:       r_circ <= i_cfg_wdata[wstc_pkg::CIRC_W-1:0];
                wstc_pkg::CFG_MAX_ACCEL:  r_max_accel <= i_cfg_wdata[wstc_pkg::Q8_W-1:0];
                wstc_pkg::CFG_MAX_SPEED:  r_max_speed <= i_cfg_wdata[wstc_pkg::Q8_W-1:0];
                wstc_pkg::CFG_MIN_SPEED:  r_min_speed <= i_cfg_wdata[wstc_pkg::Q8_W-1:0];
                wstc_pkg::CFG_RIDE_START: r_ride_start <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        start_t = TIME_WIDTH'(r_ride_start);
        ref_t   = (r_kind == wstc_pkg::KIND_DETECT && r_count == '0) ? start_t : r_last;
        dt_c    = r_now - ref_t;
        c3600_c = wstc_pkg::C3600_W'(r_circ) * wstc_pkg::C3600_W'(wstc_pkg::K_HOUR);
        lhs     = wstc_pkg::LHS_W'(quot[wstc_pkg::Q8_W-1:0] - r_held)
                  * wstc_pkg::LHS_W'(wstc_pkg::K_ACCEL);
        a9      = wstc_pkg::A9_W'(r_max_accel) * wstc_pkg::A9_W'(wstc_pkg::K_A9);
        case (i_cmd.sel)
            wstc_pkg::DS_SPEED: begin
                dvd = DVD_W'(wstc_pkg::SPDNUM_W'(r_circ)
                      * wstc_pkg::SPDNUM_W'(wstc_pkg::K_SPEED));
                dvs = dt_c;
            end
            wstc_pkg::DS_QUERY: begin
                dvd = DVD_W'(c3600_c);
                dvs = dt_c;
            end
            wstc_pkg::DS_ACCEL: begin
                dvd = DVD_W'(lhs - wstc_pkg::LHS_W'(1));
                dvs = TIME_WIDTH'(a9);
            end
            wstc_pkg::DS_AVG: begin
                dvd = DVD_W'(r_count) * DVD_W'(r_c3600);
                dvs = r_el;
            end
            default: begin
                dvd = '0;
                dvs = '0;
            end
        endcase
    end

    wstc_divider #(
        .DVD_W (DVD_W),
        .DVS_W (TIME_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.start),
        .i_dividend (dvd),
        .i_divisor  (dvs),
        .o_done     (div_done),
        .o_quot     (quot),
        .o_rem      (rem)
    );

    assign out_free = !r_valid || i_m_tready;

    always_comb begin
        o_st.kind       = r_kind;
        o_st.count_zero = (r_count == '0);
        o_st.ref_late   = (r_now <= ref_t);
        o_st.q_after    = (r_now > r_last);
        o_st.el_pos     = r_el_pos;
        o_st.div_done   = div_done;
        o_st.win_bad    = (quot < DVD_W'(r_min_speed)) || (quot > DVD_W'(r_max_speed))
                          || (quot == DVD_W'(r_max_speed) && rem != '0);
        o_st.acc_up     = (quot > DVD_W'(r_held));
        o_st.a9_zero    = (r_max_accel == '0);
        o_st.acc_bad    = (WIDE_W'(r_dt) <= WIDE_W'(quot));
        o_st.out_free   = out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held     <= '0;
            r_prior    <= '0;
            r_count    <= '0;
            r_last     <= '0;
            r_before   <= '0;
            r_held_avg <= '0;
        end else begin
            if (i_cmd.upd) begin
                r_prior  <= r_held;
                r_held   <= r_spd;
                if (!(&r_count)) begin
                    r_count <= r_count + COUNT_WIDTH'(1);
                end
                r_before <= r_last;
                r_last   <= r_now;
            end
            if (i_cmd.avg_zero && r_kind == wstc_pkg::KIND_DETECT) begin
                r_held_avg <= '0;
            end
            if (i_cmd.avg_div && r_kind == wstc_pkg::KIND_DETECT) begin
                r_held_avg <= (quot > DVD_W'(wstc_pkg::AVG_MAX)) ?
                              wstc_pkg::AVG_MAX : quot[wstc_pkg::Q8_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind <= i_kind;
            r_now  <= TIME_WIDTH'(i_now);
        end
        if (i_cmd.prep) begin
            r_dt        <= dt_c;
            r_el        <= r_now - start_t;
            r_el_pos    <= r_now > start_t;
            r_c3600     <= c3600_c;
            r_res_avg   <= r_held_avg;
            r_ok        <= 1'b0;
        end
        if (i_cmd.save_spd) begin
            r_spd <= quot[wstc_pkg::Q8_W-1:0];
        end
        if (i_cmd.upd) begin
            r_ok <= 1'b1;
        end
        // a query at or before the last spin resolves without a division
        if (i_cmd.qfix) begin
            r_res_speed <= {(r_now == r_last) ? wstc_pkg::KMH_FORCED : 8'd0, 8'd0};
        end else if (i_cmd.prep) begin
            r_res_speed <= r_held;
        end else if (i_cmd.upd) begin
            r_res_speed <= r_spd;
        end else if (i_cmd.qdiv) begin
            r_res_speed <= {(quot > DVD_W'(wstc_pkg::KMH_CAP)) ?
                            wstc_pkg::KMH_FORCED : quot[7:0], 8'd0};
        end
        if (i_cmd.avg_zero) begin
            r_res_avg <= '0;
        end
        if (i_cmd.avg_div) begin
            r_res_avg <= (quot > DVD_W'(wstc_pkg::AVG_MAX)) ?
                         wstc_pkg::AVG_MAX : quot[wstc_pkg::Q8_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_tdata <= {48'(r_before), 48'(r_last), 32'(r_count),
                        r_res_avg, r_prior, r_res_speed};
            r_tuser <= r_ok;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_tdata;
    assign o_m_tuser  = r_tuser;
endmodule

### src/wstc_ctrl.sv
// Sequencer that steps one item through the divider passes.
module wstc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  wstc_pkg::t_status i_st,
    output wstc_pkg::t_cmd    o_cmd
);
    typedef enum logic [10:0] {
        S_IDLE = 11'b000_0000_0001,
        S_PREP = 11'b000_0000_0010,
        S_WSPD = 11'b000_0000_0100,
        S_CHK  = 11'b000_0000_1000,
        S_WACC = 11'b000_0001_0000,
        S_ACHK = 11'b000_0010_0000,
        S_UPD  = 11'b000_0100_0000,
        S_WQ   = 11'b000_1000_0000,
        S_AVG  = 11'b001_0000_0000,
        S_WAVG = 11'b010_0000_0000,
        S_DONE = 11'b100_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.sel      = wstc_pkg::DS_SPEED;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                if (i_st.kind == wstc_pkg::KIND_DETECT) begin
                    if (i_st.ref_late) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.start = 1'b1;
                        o_cmd.sel   = wstc_pkg::DS_SPEED;
                        n_state     = S_WSPD;
                    end
                end else if (i_st.count_zero) begin
                    n_state = S_DONE;
                end else if (i_st.q_after) begin
                    o_cmd.start = 1'b1;
                    o_cmd.sel   = wstc_pkg::DS_QUERY;
                    n_state     = S_WQ;
                end else begin
                    o_cmd.qfix = 1'b1;
                    n_state    = S_AVG;
                end
            end
            S_WSPD: begin
                if (i_st.div_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                o_cmd.save_spd = 1'b1;
                if (i_st.win_bad) begin
                    n_state = S_DONE;
                end else if (i_st.acc_up) begin
                    if (i_st.a9_zero) begin
                        n_state = S_DONE;
                    end else begin
                        o_cmd.start = 1'b1;
                        o_cmd.sel   = wstc_pkg::DS_ACCEL;
                        n_state     = S_WACC;
                    end
                end else begin
                    n_state = S_UPD;
                end
            end
            S_WACC: begin
                if (i_st.div_done) begin
                    n_state = S_ACHK;
                end
            end
            S_ACHK: begin
                n_state = i_st.acc_bad ? S_DONE : S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_AVG;
            end
            S_WQ: begin
                if (i_st.div_done) begin
                    o_cmd.qdiv = 1'b1;
                    n_state    = S_AVG;
                end
            end
            S_AVG: begin
                if (i_st.el_pos) begin
                    o_cmd.start = 1'b1;
                    o_cmd.sel   = wstc_pkg::DS_AVG;
                    n_state     = S_WAVG;
                end else begin
                    o_cmd.avg_zero = 1'b1;
                    n_state        = S_DONE;
                end
            end
            S_WAVG: begin
                if (i_st.div_done) begin
                    o_cmd.avg_div = 1'b1;
                    n_state       = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register can take the item
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
endmodule

### src/wheel_speed_trip_computer_unit.sv
// Top level of the wheel speed trip computer.
// One item at a time: each item goes through a single shared restoring divider
// that yields one quotient bit per cycle; the dividend is D bits wide,
// with D = max(COUNT_WIDTH+24, 38) (56 by default). A detection uses up to three
// passes (speed, acceleration test, trip average); a query uses up to two.
// Detections not later than their reference time and queries before the first
// detection finish without a division pass. A finished item waits in the output
// register, and the next item is taken meanwhile.
module wheel_speed_trip_computer_unit #(
    parameter int TIME_WIDTH  = wstc_pkg::TIME_WIDTH_DEF,
    parameter int COUNT_WIDTH = wstc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_wr_en,
    input  logic [wstc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [wstc_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [47:0]                    i_s_tdata,  // now_us[47:0]
    input  logic                           i_s_tuser,  // kind
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // speed_kmh_q8[15:0], previous_speed_kmh_q8[31:16], avg_speed_kmh[47:32],
    // detection_count[79:48], latest_detection_us[127:80],
    // previous_detection_us[175:128]
    output logic [175:0]                   o_m_tdata,
    output logic                           o_m_tuser   // reading_accepted
);
    wstc_pkg::t_cmd    cmd;
    wstc_pkg::t_status st;

    wstc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    wstc_datapath #(
        .TIME_WIDTH  (TIME_WIDTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_kind      (i_s_tuser),
        .i_now       (i_s_tdata),
        .i_cmd       (cmd),
        .o_st        (st),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser)
    );
endmodule

### src/wstc_checker.sv
// Port-level checks of the trip computer, bound to the top level.
module wstc_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [175:0] o_m_tdata,
    input logic         o_m_tuser
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output item changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while one is in work");

    a_accept_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[79:48] != 32'd0)
        else $error("accepted reading with zero detection count");

    a_accept_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata[127:80] > o_m_tdata[175:128])
        else $error("accepted reading not later than the one before");
endmodule

bind wheel_speed_trip_computer_unit wstc_checker u_wstc_checker (.*);
